// ----- hw/rtl/pisr_pkg.sv -----
package pisr_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 24;

  localparam int GAIN_W = 32;
  localparam int LIM_W  = 16;
  localparam int ACC_W  = 48;
  localparam int ERR_W  = SAMPLE_BITS + 1;
  // signed product of a zero-extended gain and the error
  localparam int PROD_W = GAIN_W + 1 + ERR_W;
  localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 2'd3;

  localparam logic [GAIN_W-1:0] KP_GAIN_RST = 32'd1564937935;
  localparam logic [GAIN_W-1:0] KI_GAIN_RST = 32'd23475;
  localparam logic [LIM_W-1:0]  OUT_MIN_RST = 16'd0;
  localparam logic [LIM_W-1:0]  OUT_MAX_RST = 16'd1000;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [LIM_W-1:0]  out_min;
    logic [LIM_W-1:0]  out_max;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] kp_prod;
    logic signed [PROD_W-1:0] ki_prod;
  } prod_t;

endpackage

// ----- hw/rtl/pisr_mult_stage.sv -----
module pisr_mult_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [pisr_pkg::SAMPLE_BITS-1:0]  in_measured_speed,
  input  logic [pisr_pkg::SAMPLE_BITS-1:0]  in_reference_speed,
  input  pisr_pkg::cfg_t                    cfg,
  input  logic                              take,
  output logic                              in_stall,
  output logic                              prod_valid,
  output pisr_pkg::prod_t                   prod
);
  import pisr_pkg::*;

  logic              prod_valid_r, prod_valid_nxt;
  prod_t             prod_r, prod_nxt;
  logic signed [ERR_W-1:0] err;
  logic              adv;

  assign adv      = !prod_valid_r || take;
  assign in_stall = !adv;

  always_comb begin
    err = $signed({1'b0, in_reference_speed}) - $signed({1'b0, in_measured_speed});
    prod_nxt.kp_prod = $signed({1'b0, cfg.kp_gain}) * err;
    prod_nxt.ki_prod = $signed({1'b0, cfg.ki_gain}) * err;
    prod_valid_nxt   = adv ? in_valid : prod_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
    end
    if (adv && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

endmodule

// ----- hw/rtl/pisr_integ_stage.sv -----
module pisr_integ_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        prod_valid,
  input  pisr_pkg::prod_t             prod,
  input  pisr_pkg::cfg_t              cfg,
  input  logic                        out_stall,
  output logic                        take,
  output logic                        out_valid,
  output logic [pisr_pkg::LIM_W-1:0]  out_drive_value,
  output logic                        out_saturated
);
  import pisr_pkg::*;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [LIM_W-1:0]        drive_r, drive_nxt;
  logic                    sat_r, sat_nxt;

  logic signed [SUM_W-1:0] trial_wide, y, lo, hi;
  logic signed [ACC_W-1:0] trial;
  logic                    ovf, over_hi, under_lo, fire;

  assign take = !out_valid_r || !out_stall;
  assign fire = prod_valid && take;

  always_comb begin
    trial_wide = SUM_W'(acc_r) + SUM_W'(prod.ki_prod);
    // overflow when the bits above the 48-bit sign do not all match it
    ovf = (trial_wide[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b0}}) &&
          (trial_wide[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b1}});
    if (ovf) begin
      trial = trial_wide[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                  : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      trial = trial_wide[ACC_W-1:0];
    end
    y  = SUM_W'(prod.kp_prod) + SUM_W'(trial);
    lo = $signed({{(SUM_W-LIM_W-FRAC_BITS){1'b0}}, cfg.out_min, {FRAC_BITS{1'b0}}});
    hi = $signed({{(SUM_W-LIM_W-FRAC_BITS){1'b0}}, cfg.out_max, {FRAC_BITS{1'b0}}});
    over_hi  = y > hi;
    under_lo = y < lo;

    acc_nxt = (fire && !over_hi && !under_lo) ? trial : acc_r;

    // upper clamp first, then lower: inverted limits end at out_min
    priority if (over_hi) begin
      drive_nxt = (cfg.out_max < cfg.out_min) ? cfg.out_min : cfg.out_max;
    end else if (under_lo) begin
      drive_nxt = cfg.out_min;
    end else begin
      drive_nxt = y[FRAC_BITS+LIM_W-1:FRAC_BITS];
    end
    sat_nxt = over_hi || under_lo;
    out_valid_nxt = take ? prod_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (fire) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = drive_r;
  assign out_saturated   = sat_r;

endmodule

// ----- hw/rtl/pi_speed_regulator_antiwindup.sv -----
// channel | ports                                         | direction
// in      | in_valid, in_stall, in_measured_speed,        | item in
//         | in_reference_speed                            |
// out     | out_valid, out_stall, out_drive_value,        | item out
//         | out_saturated                                 |
// cfg     | cfg_we, cfg_index, cfg_wdata                  | register write
//
// One item per cycle while out_stall is low; each item passes the product register, then the result register.
// The rate is set by the integrator update, done once per cycle in the result stage when it takes an item.
// rst_n (synchronous) clears the integrator, valid flags and gains/limits to defaults.
// out_stall holds the result register; the product stage still takes one item if it is empty,
// then in_stall rises.
module pi_speed_regulator_antiwindup (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pisr_pkg::SAMPLE_BITS-1:0]  in_measured_speed,
  input  logic [pisr_pkg::SAMPLE_BITS-1:0]  in_reference_speed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pisr_pkg::LIM_W-1:0]        out_drive_value,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [pisr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pisr_pkg::CFG_W-1:0]        cfg_wdata
);
  import pisr_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  prod_t prod;
  logic  prod_valid, take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP_GAIN: cfg_nxt.kp_gain = cfg_wdata;
        CFG_KI_GAIN: cfg_nxt.ki_gain = cfg_wdata;
        CFG_OUT_MIN: cfg_nxt.out_min = cfg_wdata[LIM_W-1:0];
        CFG_OUT_MAX: cfg_nxt.out_max = cfg_wdata[LIM_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain <= KP_GAIN_RST;
      cfg_r.ki_gain <= KI_GAIN_RST;
      cfg_r.out_min <= OUT_MIN_RST;
      cfg_r.out_max <= OUT_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pisr_mult_stage u_mult (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_measured_speed  (in_measured_speed),
    .in_reference_speed (in_reference_speed),
    .cfg                (cfg_r),
    .take               (take),
    .in_stall           (in_stall),
    .prod_valid         (prod_valid),
    .prod               (prod)
  );

  pisr_integ_stage u_integ (
    .clk             (clk),
    .rst_n           (rst_n),
    .prod_valid      (prod_valid),
    .prod            (prod),
    .cfg             (cfg_r),
    .out_stall       (out_stall),
    .take            (take),
    .out_valid       (out_valid),
    .out_drive_value (out_drive_value),
    .out_saturated   (out_saturated)
  );

endmodule

// ----- hw/rtl/pisr_checker.sv -----
module pisr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [pisr_pkg::LIM_W-1:0]        out_drive_value,
  input logic                              out_saturated,
  input logic                              cfg_we,
  input logic [pisr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [pisr_pkg::CFG_W-1:0]        cfg_wdata
);
  import pisr_pkg::*;

  // shadow copy of the clamp limits
  logic [LIM_W-1:0] min_r, max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= OUT_MIN_RST;
      max_r <= OUT_MAX_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OUT_MIN) begin
        min_r <= cfg_wdata[LIM_W-1:0];
      end
      if (cfg_index == CFG_OUT_MAX) begin
        max_r <= cfg_wdata[LIM_W-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_value)
      && $stable(out_saturated))
    else $error("result changed while stalled");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("item did not reach the output in two cycles");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_saturated |-> out_drive_value >= min_r && out_drive_value <= max_r)
    else $error("unsaturated drive value outside limits");

  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated && min_r <= max_r |->
      out_drive_value == min_r || out_drive_value == max_r)
    else $error("saturated drive value not at a limit");

endmodule

bind pi_speed_regulator_antiwindup pisr_checker u_pisr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_drive_value (out_drive_value),
  .out_saturated   (out_saturated),
  .cfg_we          (cfg_we),
  .cfg_index       (cfg_index),
  .cfg_wdata       (cfg_wdata)
);
